// File: src/tsbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsbm_pkg;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_RUN    = 2'd3;

  localparam logic [1:0] ST_ORDER = 2'd0;
  localparam logic [1:0] ST_CYCLE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_EDIT  = 2'd3;

  localparam int unsigned MAX_OUT = 32;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CNT_W   = 6;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

endpackage

`default_nettype wire

// File: src/tsbm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tsbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/topological_sort_bit_matrix.sv
`timescale 1ns / 1ps
`default_nettype none

// Topological sort over a bit matrix of dependency edges held in a one-port-read
// edge memory (one row per node) plus a 32-entry order memory. Add, remove and
// clear each take one beat and present one result beat (status edit): the edge
// row is read on accept, add and remove write it back in the edit state, and
// the result passes from the response state into the output register when free;
// clear takes effect at once through per-row valid bits, so there is no clearing
// pass. A run reads one edge row per cycle: each pick scans rows from node 0
// until the first ready node, and once every tracked node is picked the order
// memory is read before the results are streamed at one beat per cycle while
// the receiver does not stall. The edge memory read port sets the scan rate.
// The block takes a new input beat only when the previous item has been fully
// handed to the output register.
module topological_sort_bit_matrix
  import tsbm_pkg::*;
#(
  parameter int NODE_COUNT = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_mode,
  input  wire logic [4:0] in_object_index,
  input  wire logic [4:0] in_dependency_index,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [1:0] out_status,
  output logic      [4:0] out_node,
  output logic            out_edge_was_new,
  output logic            out_last
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int SW = $clog2(NODE_COUNT + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EDIT    = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_EMIT_RD = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;
  localparam logic [2:0] S_RESP    = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [NODE_COUNT-1:0] tracked_r, tracked_nxt;
  logic [NODE_COUNT-1:0] removed_r, removed_nxt;
  logic [NODE_COUNT-1:0] row_valid_r, row_valid_nxt;
  cnt_t                  cnt_r, cnt_nxt;
  logic [SW-1:0]         scan_r, scan_nxt;
  logic                  eval_v_r, eval_v_nxt;
  logic [AW-1:0]         eval_idx_r, eval_idx_nxt;
  idx_t                  emit_r, emit_nxt;
  logic [1:0]            ed_mode_r, ed_mode_nxt;
  logic [AW-1:0]         ed_obj_r, ed_obj_nxt;
  logic [AW-1:0]         ed_dep_r, ed_dep_nxt;
  logic                  ed_ok_r, ed_ok_nxt;
  logic [1:0]            resp_status_r, resp_status_nxt;
  logic                  resp_new_r, resp_new_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  idx_t                  out_node_r, out_node_nxt;
  logic                  out_new_r, out_new_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  em_wr_en, em_rd_en;
  logic [AW-1:0]         em_wr_addr, em_rd_addr;
  logic [NODE_COUNT-1:0] em_wr_data, em_rd_data;
  logic                  ob_wr_en, ob_rd_en;
  idx_t                  ob_wr_addr, ob_rd_addr;
  idx_t                  ob_wr_data, ob_rd_data;

  logic                  accept, out_free, hit, in_ok;
  logic [AW-1:0]         in_obj_a, in_dep_a;
  logic [NODE_COUNT-1:0] edit_row, eval_row, dep_bit, pick_bit;

  tsbm_ram #(.WIDTH(NODE_COUNT), .DEPTH(NODE_COUNT)) u_edge_mem (
    .clk    (clk),
    .wr_en  (em_wr_en),
    .wr_addr(em_wr_addr),
    .wr_data(em_wr_data),
    .rd_en  (em_rd_en),
    .rd_addr(em_rd_addr),
    .rd_data(em_rd_data)
  );

  tsbm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_OUT)) u_order_mem (
    .clk    (clk),
    .wr_en  (ob_wr_en),
    .wr_addr(ob_wr_addr),
    .wr_data(ob_wr_data),
    .rd_en  (ob_rd_en),
    .rd_addr(ob_rd_addr),
    .rd_data(ob_rd_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_ok    = ({2'b00, in_object_index} < 7'(NODE_COUNT))
                 && ({2'b00, in_dependency_index} < 7'(NODE_COUNT));
  assign in_obj_a = AW'({2'b00, in_object_index});
  assign in_dep_a = AW'({2'b00, in_dependency_index});

  // rows never written since the last clear read as empty
  assign edit_row = row_valid_r[ed_obj_r] ? em_rd_data : '0;
  assign eval_row = row_valid_r[eval_idx_r] ? em_rd_data : '0;
  assign dep_bit  = NODE_COUNT'(1) << ed_dep_r;
  assign pick_bit = NODE_COUNT'(1) << eval_idx_r;
  assign hit      = (state_r == S_SCAN) && eval_v_r && tracked_r[eval_idx_r]
                 && !removed_r[eval_idx_r] && ((eval_row & ~removed_r) == '0);

  always_comb begin
    state_nxt       = state_r;
    tracked_nxt     = tracked_r;
    removed_nxt     = removed_r;
    row_valid_nxt   = row_valid_r;
    cnt_nxt         = cnt_r;
    scan_nxt        = scan_r;
    eval_v_nxt      = 1'b0;
    eval_idx_nxt    = eval_idx_r;
    emit_nxt        = emit_r;
    ed_mode_nxt     = ed_mode_r;
    ed_obj_nxt      = ed_obj_r;
    ed_dep_nxt      = ed_dep_r;
    ed_ok_nxt       = ed_ok_r;
    resp_status_nxt = resp_status_r;
    resp_new_nxt    = resp_new_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_node_nxt    = out_node_r;
    out_new_nxt     = out_new_r;
    out_last_nxt    = out_last_r;
    em_wr_en        = 1'b0;
    em_wr_addr      = ed_obj_r;
    em_wr_data      = edit_row;
    em_rd_en        = 1'b0;
    em_rd_addr      = in_obj_a;
    ob_wr_en        = 1'b0;
    ob_wr_addr      = cnt_r[IDX_W-1:0];
    ob_wr_data      = IDX_W'(7'(eval_idx_r));
    ob_rd_en        = 1'b0;
    ob_rd_addr      = emit_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ed_mode_nxt = in_mode;
          ed_obj_nxt  = in_obj_a;
          ed_dep_nxt  = in_dep_a;
          ed_ok_nxt   = in_ok;
          if (in_mode == MODE_RUN) begin
            removed_nxt = '0;
            cnt_nxt     = '0;
            scan_nxt    = '0;
            if (tracked_r == '0) begin
              resp_status_nxt = ST_EMPTY;
              resp_new_nxt    = 1'b0;
              state_nxt       = S_RESP;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            em_rd_en  = 1'b1;
            state_nxt = S_EDIT;
          end
        end
      end

      S_EDIT: begin
        resp_status_nxt = ST_EDIT;
        resp_new_nxt    = 1'b0;
        state_nxt       = S_RESP;
        case (ed_mode_r)
          MODE_ADD: begin
            if (ed_ok_r) begin
              em_wr_en                = 1'b1;
              em_wr_data              = edit_row | dep_bit;
              row_valid_nxt[ed_obj_r] = 1'b1;
              tracked_nxt             = tracked_r | dep_bit | (NODE_COUNT'(1) << ed_obj_r);
              resp_new_nxt            = ((edit_row & dep_bit) == '0);
            end
          end
          MODE_REMOVE: begin
            if (ed_ok_r) begin
              em_wr_en                = 1'b1;
              em_wr_data              = edit_row & ~dep_bit;
              row_valid_nxt[ed_obj_r] = 1'b1;
            end
          end
          default: begin
            row_valid_nxt = '0;
            tracked_nxt   = '0;
            removed_nxt   = '0;
            cnt_nxt       = '0;
          end
        endcase
      end

      S_SCAN: begin
        if (scan_r < SW'(NODE_COUNT)) begin
          em_rd_en     = 1'b1;
          em_rd_addr   = AW'(scan_r);
          scan_nxt     = scan_r + SW'(1);
          eval_v_nxt   = 1'b1;
          eval_idx_nxt = AW'(scan_r);
        end
        if (hit && (cnt_r < CNT_W'(MAX_OUT))) begin
          ob_wr_en    = 1'b1;
          cnt_nxt     = cnt_r + CNT_W'(1);
          removed_nxt = removed_r | pick_bit;
          scan_nxt    = '0;
          eval_v_nxt  = 1'b0;
          if ((tracked_r & ~(removed_r | pick_bit)) == '0) begin
            emit_nxt  = '0;
            state_nxt = S_EMIT_RD;
          end
        end else if (hit || (eval_v_r && (eval_idx_r == AW'(NODE_COUNT - 1)))) begin
          // no ready node left: dependency cycle
          cnt_nxt         = '0;
          eval_v_nxt      = 1'b0;
          resp_status_nxt = ST_CYCLE;
          resp_new_nxt    = 1'b0;
          state_nxt       = S_RESP;
        end
      end

      S_EMIT_RD: begin
        ob_rd_en  = 1'b1;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_ORDER;
          out_node_nxt   = ob_rd_data;
          out_new_nxt    = 1'b0;
          out_last_nxt   = (({1'b0, emit_r} + CNT_W'(1)) == cnt_r);
          if (out_last_nxt) begin
            state_nxt = S_IDLE;
          end else begin
            emit_nxt   = emit_r + IDX_W'(1);
            ob_rd_en   = 1'b1;
            ob_rd_addr = emit_nxt;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_status_r;
          out_node_nxt   = '0;
          out_new_nxt    = resp_new_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tracked_r   <= '0;
      removed_r   <= '0;
      row_valid_r <= '0;
      cnt_r       <= '0;
      scan_r      <= '0;
      eval_v_r    <= 1'b0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tracked_r   <= tracked_nxt;
      removed_r   <= removed_nxt;
      row_valid_r <= row_valid_nxt;
      cnt_r       <= cnt_nxt;
      scan_r      <= scan_nxt;
      eval_v_r    <= eval_v_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r    <= eval_idx_nxt;
    ed_mode_r     <= ed_mode_nxt;
    ed_obj_r      <= ed_obj_nxt;
    ed_dep_r      <= ed_dep_nxt;
    ed_ok_r       <= ed_ok_nxt;
    resp_status_r <= resp_status_nxt;
    resp_new_r    <= resp_new_nxt;
    out_status_r  <= out_status_nxt;
    out_node_r    <= out_node_nxt;
    out_new_r     <= out_new_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_node         = out_node_r;
  assign out_edge_was_new = out_new_r;
  assign out_last         = out_last_r;

`ifndef SYNTH
  // a scan only runs while some tracked node is still unordered
  a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((tracked_r & ~removed_r) != '0))
    else $error("scan with no unordered tracked node");

  // each pick removes exactly one new node
  a_pick_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (hit && (cnt_r < CNT_W'(MAX_OUT))) |=>
      ($countones(removed_r) == $past($countones(removed_r)) + 1))
    else $error("pick did not grow removed set by one");

  // single-beat results always close their item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_ORDER)) |-> out_last_r)
    else $error("non-order beat without last");

  a_new_only_edit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_new_r) |-> (out_status_r == ST_EDIT))
    else $error("edge_was_new on non-edit beat");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) || (state_r == S_EMIT_RD)) |-> (cnt_r != '0))
    else $error("emitting an empty order");
`endif

endmodule

`default_nettype wire

// File: tb/topo_order_checker.sv
`timescale 1ns / 1ps

module topo_order_checker
  import tsbm_pkg::*;
#(
  parameter int NODE_COUNT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_mode,
  input  idx_t       in_object_index,
  input  idx_t       in_dependency_index,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_status,
  input  idx_t       out_node,
  input  logic       out_edge_was_new,
  input  logic       out_last,
  output int         mismatch_count,
  output int         pending_beats
);

  typedef struct packed {
    logic [1:0] status;
    idx_t       node;
    logic       edge_was_new;
    logic       last;
  } order_beat_t;

  logic [NODE_COUNT-1:0] dep_rows [NODE_COUNT];
  logic [NODE_COUNT-1:0] tracked_nodes;
  order_beat_t           expected_beats [$];

  function automatic order_beat_t make_beat(logic [1:0] st, idx_t nd, logic nw, logic ls);
    order_beat_t b;
    b.status       = st;
    b.node         = nd;
    b.edge_was_new = nw;
    b.last         = ls;
    return b;
  endfunction

  function automatic void queue_beat(order_beat_t b);
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  // lowest-index ready node first, a pick with no ready node means a cycle
  task automatic predict_order();
    logic [NODE_COUNT-1:0] placed;
    idx_t                  picks [$];
    logic                  blocked;
    int                    pick;
    placed  = '0;
    blocked = 1'b0;
    if (tracked_nodes == '0) begin
      queue_beat(make_beat(ST_EMPTY, '0, 1'b0, 1'b1));
    end else begin
      while (!blocked && (tracked_nodes & ~placed) != '0) begin
        pick = -1;
        for (int i = 0; i < NODE_COUNT; i++) begin
          if (pick < 0 && tracked_nodes[i] && !placed[i] && (dep_rows[i] & ~placed) == '0) begin
            pick = i;
          end
        end
        if (pick < 0 || picks.size() >= MAX_OUT) begin
          blocked = 1'b1;
        end else begin
          picks.insert(picks.size(), idx_t'(pick));
          placed[pick] = 1'b1;
        end
      end
      if (blocked) begin
        queue_beat(make_beat(ST_CYCLE, '0, 1'b0, 1'b1));
      end else begin
        foreach (picks[k]) begin
          queue_beat(make_beat(ST_ORDER, picks[k], 1'b0, k == picks.size() - 1));
        end
      end
    end
  endtask

  task automatic predict_beat(logic [1:0] mode, idx_t obj, idx_t dep);
    logic in_range;
    logic was_new;
    in_range = (obj < NODE_COUNT) && (dep < NODE_COUNT);
    was_new  = 1'b0;
    case (mode)
      MODE_ADD: begin
        if (in_range) begin
          tracked_nodes[obj] = 1'b1;
          tracked_nodes[dep] = 1'b1;
          was_new            = !dep_rows[obj][dep];
          dep_rows[obj][dep] = 1'b1;
        end
        queue_beat(make_beat(ST_EDIT, '0, was_new, 1'b1));
      end
      MODE_REMOVE: begin
        if (in_range) begin
          dep_rows[obj][dep] = 1'b0;
        end
        queue_beat(make_beat(ST_EDIT, '0, 1'b0, 1'b1));
      end
      MODE_CLEAR: begin
        foreach (dep_rows[r]) dep_rows[r] = '0;
        tracked_nodes = '0;
        queue_beat(make_beat(ST_EDIT, '0, 1'b0, 1'b1));
      end
      default: begin
        predict_order();
      end
    endcase
  endtask

  always @(posedge clk) begin
    order_beat_t got;
    order_beat_t want;
    if (!rst_n) begin
      foreach (dep_rows[r]) dep_rows[r] = '0;
      tracked_nodes = '0;
      expected_beats.delete();
      mismatch_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_beat(in_mode, in_object_index, in_dependency_index);
      end
      if (out_valid && !out_stall) begin
        got = make_beat(out_status, out_node, out_edge_was_new, out_last);
        if (expected_beats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result beat with nothing expected: status %0d node %0d new %b last %b",
                     $realtime, got.status, got.node, got.edge_was_new, got.last);
          end
        end else begin
          want = expected_beats.pop_front();
          if (got.status !== want.status || got.node !== want.node ||
              got.edge_was_new !== want.edge_was_new || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display({"%0t: result beat mismatch: expected status %0d node %0d new %b last %b,",
                        " got status %0d node %0d new %b last %b"},
                       $realtime, want.status, want.node, want.edge_was_new, want.last,
                       got.status, got.node, got.edge_was_new, got.last);
            end
          end
        end
      end
    end
    pending_beats = expected_beats.size();
  end

endmodule

// File: tb/tb_topological_sort_bit_matrix.sv
`timescale 1ns / 1ps

module tb_topological_sort_bit_matrix;
  import tsbm_pkg::*;

  localparam int NODE_COUNT  = 32;
  localparam int STUCK_LIMIT = 20000;
  localparam int ITEM_TARGET = 480;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_mode = MODE_CLEAR;
  idx_t       in_object_index = '0;
  idx_t       in_dependency_index = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  idx_t       out_node;
  logic       out_edge_was_new;
  logic       out_last;

  int mismatch_count;
  int pending_beats;
  int beats_sent = 0;
  int burst_left = 4;
  int stall_seg_left = 0;
  int stall_kind = 0;
  int stall_period = 3;
  int stall_phase = 0;
  int stuck_cycles = 0;

  always #4 clk = ~clk;

  topological_sort_bit_matrix #(
    .NODE_COUNT(NODE_COUNT)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_object_index     (in_object_index),
    .in_dependency_index (in_dependency_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_node            (out_node),
    .out_edge_was_new    (out_edge_was_new),
    .out_last            (out_last)
  );

  topo_order_checker #(
    .NODE_COUNT(NODE_COUNT)
  ) order_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_object_index     (in_object_index),
    .in_dependency_index (in_dependency_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_node            (out_node),
    .out_edge_was_new    (out_edge_was_new),
    .out_last            (out_last),
    .mismatch_count      (mismatch_count),
    .pending_beats       (pending_beats)
  );

  // receiver stall pattern in segments
  always @(negedge clk) begin
    if (stall_seg_left == 0) begin
      stall_kind     = $urandom_range(0, 3);
      stall_period   = $urandom_range(2, 5);
      stall_seg_left = $urandom_range(20, 200);
      stall_phase    = 0;
    end
    stall_seg_left--;
    stall_phase++;
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_phase % stall_period == 0);
    endcase
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_beat(logic [1:0] mode, idx_t obj, idx_t dep);
    @(negedge clk);
    in_valid            <= 1'b1;
    in_mode             <= mode;
    in_object_index     <= obj;
    in_dependency_index <= dep;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_valid            <= 1'b0;
      in_mode             <= 2'($urandom_range(0, 3));
      in_object_index     <= idx_t'($urandom_range(0, 31));
      in_dependency_index <= idx_t'($urandom_range(0, 31));
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic send_run();
    send_beat(MODE_RUN, idx_t'($urandom_range(0, 31)), idx_t'($urandom_range(0, 31)));
  endtask

  // random dag over a shuffled node subset, sometimes closed into a cycle
  task automatic build_and_order();
    int perm [32];
    int n;
    int a;
    int b;
    int tmp;
    int j;
    foreach (perm[i]) perm[i] = i;
    for (int i = 31; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    n = ($urandom_range(0, 5) == 0) ? 32 : $urandom_range(1, 12);
    send_beat(MODE_CLEAR, idx_t'($urandom_range(0, 31)), idx_t'($urandom_range(0, 31)));
    for (int k = 1; k < n; k++) begin
      send_beat(MODE_ADD, idx_t'(perm[k]), idx_t'(perm[$urandom_range(0, k - 1)]));
    end
    if (n > 1) begin
      repeat ($urandom_range(0, n)) begin
        a = $urandom_range(1, n - 1);
        b = $urandom_range(0, a - 1);
        send_beat(MODE_ADD, idx_t'(perm[a]), idx_t'(perm[b]));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(a, n - 1);
      send_beat(MODE_ADD, idx_t'(perm[a]), idx_t'(perm[b]));
      if ($urandom_range(0, 1) == 0) begin
        send_beat(MODE_REMOVE, idx_t'(perm[a]), idx_t'(perm[b]));
      end
    end
    send_run();
    if (n > 1 && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        a = $urandom_range(1, n - 1);
        b = $urandom_range(0, a - 1);
        send_beat(MODE_REMOVE, idx_t'(perm[a]), idx_t'(perm[b]));
      end
      send_run();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_beat(MODE_RUN, 5'd31, 5'd0);
    send_beat(MODE_ADD, 5'd0, 5'd31);
    send_beat(MODE_ADD, 5'd0, 5'd31);
    send_beat(MODE_ADD, 5'd5, 5'd0);
    send_beat(MODE_RUN, 5'd0, 5'd31);
    send_beat(MODE_REMOVE, 5'd0, 5'd31);
    send_beat(MODE_REMOVE, 5'd0, 5'd31);
    send_beat(MODE_RUN, 5'd31, 5'd31);
    send_beat(MODE_ADD, 5'd7, 5'd7);
    send_beat(MODE_RUN, 5'd0, 5'd0);
    send_beat(MODE_REMOVE, 5'd7, 5'd7);
    send_beat(MODE_RUN, 5'd21, 5'd10);
    send_beat(MODE_ADD, 5'd12, 5'd31);
    send_beat(MODE_ADD, 5'd31, 5'd12);
    send_beat(MODE_RUN, 5'd10, 5'd21);
    send_beat(MODE_CLEAR, 5'd31, 5'd31);
    send_beat(MODE_RUN, 5'd0, 5'd0);
    send_beat(MODE_ADD, 5'd31, 5'd30);
    send_beat(MODE_ADD, 5'd30, 5'd1);
    send_beat(MODE_ADD, 5'd1, 5'd0);
    send_beat(MODE_RUN, 5'd0, 5'd0);
    send_beat(MODE_CLEAR, 5'd0, 5'd0);

    while (beats_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        7, 8: begin
          repeat ($urandom_range(1, 6)) begin
            send_beat(2'($urandom_range(0, 3)), idx_t'($urandom_range(0, 31)),
                      idx_t'($urandom_range(0, 31)));
          end
        end
        9: send_run();
        default: build_and_order();
      endcase
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
